// ----- hw/rtl/rle_row_encoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the row run-length encoder.
// Each macro expands to a clocked concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef RLE_ROW_ENCODER_TOP_DEFINES_SVH
`define RLE_ROW_ENCODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RLE_ASSERT(lbl, prop, msg)
`define RLE_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/rle_pkg.sv -----
// ----------------------------------------------------------------------------
// Row run-length encoder package
// Payload types of the pixel and result channels and the code byte constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rle_pkg;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
  } rle_in_t;

  typedef struct packed {
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [7:0] out_byte_4;
    logic [7:0] out_byte_5;
    logic [7:0] out_byte_6;
    logic [7:0] out_byte_7;
    logic [3:0] byte_count;
    logic       burst_last;
    logic       row_done;
  } rle_out_t;

  localparam logic [7:0] LIT_FLAG = 8'h80;
  localparam logic [7:0] CNT_MASK = 8'h7f;
  localparam int unsigned PACK_BYTES = 8;

endpackage

`default_nettype wire

// ----- hw/rtl/rle_row_encoder_top.sv -----
// ----------------------------------------------------------------------------
// Row run-length encoder
// Encodes one channel of an image row into repeat and literal runs and packs
// the code bytes into multi-byte result transfers.
// ----------------------------------------------------------------------------
// A pixel that only extends a run is taken while the sequencer is idle. A
// pixel that closes a run starts the sequencer, which emits one code byte per
// cycle unless an output stall holds a result; literal bytes come out of the
// literal memory through its single registered read port. A row end adds the
// terminator byte, and when the final pixel is coded as a literal it is first
// stored in the literal memory. Output stalls hold the sequencer only when a
// finished result cannot move into the output register.
`default_nettype none
`include "rle_row_encoder_top_defines.svh"

module rle_row_encoder_top #(
  parameter int unsigned MAX_RUN          = 127,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rle_pkg::rle_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rle_pkg::rle_out_t      out_data
);

  import rle_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned ADDR_W = $clog2(MAX_RUN);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REP_CNT = 3'd1;
  localparam logic [2:0] S_REP_VAL = 3'd2;
  localparam logic [2:0] S_LIT_HDR = 3'd3;
  localparam logic [2:0] S_LIT_DAT = 3'd4;
  localparam logic [2:0] S_PUSH    = 3'd5;
  localparam logic [2:0] S_TERM    = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [7:0]        held_r, held_nxt;
  logic              hv_r, hv_nxt;
  logic [CNT_W-1:0]  rep_cnt_r, rep_cnt_nxt;
  logic [7:0]        rep_val_r, rep_val_nxt;
  logic [CNT_W-1:0]  lit_n_r, lit_n_nxt;
  logic              last_r, last_nxt;
  logic              ph2_r, ph2_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic [7:0]        mem [MAX_RUN];
  logic [7:0]        mem_rd_r;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic              in_acc;
  logic              emit_v;
  logic [7:0]        emit_byte;
  logic              emit_final;
  logic              lit_last;
  logic              push_out;
  logic              out_free;
  logic              go;

  logic [2:0]        pk_cnt_r;
  logic [7:0][7:0]   pk_data_r;
  logic [7:0][7:0]   pk_word;
  logic              out_valid_r;
  rle_out_t          out_data_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign lit_last  = ((CNT_W'(idx_r) + CNT_W'(1)) == lit_n_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    emit_v     = 1'b0;
    emit_byte  = '0;
    emit_final = 1'b0;
    unique case (state_r)
      S_REP_CNT: begin
        emit_v    = 1'b1;
        emit_byte = 8'(rep_cnt_r) & CNT_MASK;
      end
      S_REP_VAL: begin
        emit_v     = 1'b1;
        emit_byte  = rep_val_r;
        emit_final = !last_r;
      end
      S_LIT_HDR: begin
        emit_v    = 1'b1;
        emit_byte = LIT_FLAG | 8'(lit_n_r);
      end
      S_LIT_DAT: begin
        emit_v     = 1'b1;
        emit_byte  = mem_rd_r;
        emit_final = lit_last && !last_r;
      end
      S_TERM: begin
        emit_v     = 1'b1;
        emit_final = 1'b1;
      end
      default: begin
        emit_v = 1'b0;
      end
    endcase
    push_out = emit_final || (pk_cnt_r == 3'(BYTES_PER_RESULT - 1));
    go       = emit_v && (out_free || !push_out);
  end

  always_comb begin
    state_nxt   = state_r;
    lc_nxt      = lc_r;
    rc_nxt      = rc_r;
    held_nxt    = held_r;
    hv_nxt      = hv_r;
    rep_cnt_nxt = rep_cnt_r;
    rep_val_nxt = rep_val_r;
    lit_n_nxt   = lit_n_r;
    last_nxt    = last_r;
    ph2_nxt     = ph2_r;
    idx_nxt     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = lc_r[ADDR_W-1:0];
    wr_data     = held_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_data.row_end;
          ph2_nxt  = 1'b0;
          if (!hv_r) begin
            held_nxt = in_data.pixel;
            hv_nxt   = 1'b1;
          end else if (rc_r != '0) begin
            if ((in_data.pixel == held_r) && (rc_r < CNT_W'(MAX_RUN))) begin
              rc_nxt = rc_r + CNT_W'(1);
            end else begin
              rep_cnt_nxt = rc_r;
              rep_val_nxt = held_r;
              rc_nxt      = '0;
              held_nxt    = in_data.pixel;
              state_nxt   = S_REP_CNT;
            end
          end else if (in_data.pixel == held_r) begin
            if (lc_r != '0) begin
              lit_n_nxt = lc_r;
              lc_nxt    = '0;
              state_nxt = S_LIT_HDR;
            end
            rc_nxt = CNT_W'(2);
          end else begin
            wr_en = 1'b1;
            if (lc_r == CNT_W'(MAX_RUN - 1)) begin
              lit_n_nxt = CNT_W'(MAX_RUN);
              lc_nxt    = '0;
              state_nxt = S_LIT_HDR;
            end else begin
              lc_nxt = lc_r + CNT_W'(1);
            end
            held_nxt = in_data.pixel;
          end
          if ((state_nxt == S_IDLE) && in_data.row_end) begin
            ph2_nxt = 1'b1;
            if (rc_nxt != '0) begin
              rep_cnt_nxt = rc_nxt;
              rep_val_nxt = held_nxt;
              state_nxt   = S_REP_CNT;
            end else begin
              state_nxt = S_PUSH;
            end
          end
        end
      end
      S_REP_CNT: begin
        if (go) begin
          state_nxt = S_REP_VAL;
        end
      end
      S_LIT_HDR: begin
        if (go) begin
          idx_nxt   = '0;
          state_nxt = S_LIT_DAT;
        end
      end
      S_REP_VAL, S_LIT_DAT: begin
        if (go) begin
          if ((state_r == S_LIT_DAT) && !lit_last) begin
            idx_nxt = idx_r + ADDR_W'(1);
          end else if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (ph2_r) begin
            state_nxt = S_TERM;
          end else begin
            ph2_nxt = 1'b1;
            if (rc_r != '0) begin
              rep_cnt_nxt = rc_r;
              rep_val_nxt = held_r;
              state_nxt   = S_REP_CNT;
            end else begin
              state_nxt = S_PUSH;
            end
          end
        end
      end
      S_PUSH: begin
        wr_en     = 1'b1;
        lit_n_nxt = lc_r + CNT_W'(1);
        state_nxt = S_LIT_HDR;
      end
      S_TERM: begin
        if (go) begin
          lc_nxt    = '0;
          rc_nxt    = '0;
          held_nxt  = '0;
          hv_nxt    = 1'b0;
          ph2_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rd_r <= mem[idx_nxt];
  end

  always_comb begin
    pk_word           = pk_data_r;
    pk_word[pk_cnt_r] = emit_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lc_r        <= '0;
      rc_r        <= '0;
      held_r      <= '0;
      hv_r        <= 1'b0;
      last_r      <= 1'b0;
      ph2_r       <= 1'b0;
      pk_cnt_r    <= '0;
      pk_data_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      rc_r    <= rc_nxt;
      held_r  <= held_nxt;
      hv_r    <= hv_nxt;
      last_r  <= last_nxt;
      ph2_r   <= ph2_nxt;
      if (go && push_out) begin
        pk_cnt_r    <= '0;
        pk_data_r   <= '0;
        out_valid_r <= 1'b1;
      end else begin
        if (go) begin
          pk_cnt_r  <= pk_cnt_r + 3'd1;
          pk_data_r <= pk_word;
        end
        if (!out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rep_cnt_r <= rep_cnt_nxt;
    rep_val_r <= rep_val_nxt;
    lit_n_r   <= lit_n_nxt;
    idx_r     <= idx_nxt;
    if (go && push_out) begin
      out_data_r.out_byte_0 <= pk_word[0];
      out_data_r.out_byte_1 <= pk_word[1];
      out_data_r.out_byte_2 <= pk_word[2];
      out_data_r.out_byte_3 <= pk_word[3];
      out_data_r.out_byte_4 <= pk_word[4];
      out_data_r.out_byte_5 <= pk_word[5];
      out_data_r.out_byte_6 <= pk_word[6];
      out_data_r.out_byte_7 <= pk_word[7];
      out_data_r.byte_count <= 4'(pk_cnt_r) + 4'd1;
      out_data_r.burst_last <= emit_final;
      out_data_r.row_done   <= (state_r == S_TERM);
    end
  end

  `RLE_ASSERT(a_lit_count_range, lc_r < CNT_W'(MAX_RUN), "Pending literal count reached the run limit.")
  `RLE_ASSERT_IMP(a_repeat_no_literals, rc_r != '0, lc_r == '0, "Repeat run open with literals pending.")
  `RLE_ASSERT_IMP(a_term_after_row_end, state_r == S_TERM, last_r && ph2_r, "Terminator outside a row end.")
  `RLE_ASSERT_IMP(a_done_is_final, out_valid_r && out_data_r.row_done, out_data_r.burst_last, "Row done transfer is not the final one.")
  `RLE_ASSERT(a_pack_count_range, {1'b0, pk_cnt_r} < 4'(BYTES_PER_RESULT), "Packer count beyond the bytes per result.")

endmodule

`default_nettype wire

// ----- tb/rle_row_encoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// Row run-length encoder testbench
// Sends rows of pixel bytes through the encoder with random idle cycles on
// both channels. A scoreboard predicts the packed code byte transfers of
// every accepted pixel and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module rle_row_encoder_top_tb;
  import rle_pkg::*;

  localparam int unsigned RUN_LIMIT      = 127;
  localparam logic [7:0]  ROW_TERMINATOR = 8'h00;
  localparam int unsigned RANDOM_PIXELS  = 280;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned DRAIN_CYCLES   = 40;

  class row_code_scoreboard;
    logic [7:0]  literal_mem [RUN_LIMIT];
    int unsigned literal_len;
    int unsigned repeat_len;
    logic [7:0]  held_px;
    bit          held_ok;
    logic [7:0]  code_stream [$];
    rle_out_t    expected_words [$];
    int unsigned errors;
    int unsigned pixels;
    int unsigned rows;
    int unsigned words_checked;

    function new();
      literal_len = 0;
      repeat_len = 0;
      held_px = '0;
      held_ok = 1'b0;
      errors = 0;
      pixels = 0;
      rows = 0;
      words_checked = 0;
    endfunction

    function void store_literal(logic [7:0] v);
      if (literal_len < RUN_LIMIT) begin
        literal_mem[literal_len] = v;
        literal_len++;
      end
    endfunction

    function void close_literal();
      if (literal_len == 0) return;
      code_stream.push_back(LIT_FLAG | (8'(literal_len) & CNT_MASK));
      for (int unsigned i = 0; i < literal_len; i++) code_stream.push_back(literal_mem[i]);
      literal_len = 0;
    endfunction

    function void close_repeat();
      code_stream.push_back(8'(repeat_len) & CNT_MASK);
      code_stream.push_back(held_px);
      repeat_len = 0;
    endfunction

    function void note_pixel(logic [7:0] px, logic last);
      int unsigned n_words;
      int unsigned base;
      int unsigned cnt;
      logic [63:0] packed_bytes;
      rle_out_t    word;
      code_stream = {};
      pixels++;
      if (!held_ok) begin
        held_px = px;
        held_ok = 1'b1;
      end else if (repeat_len > 0) begin
        if (px == held_px && repeat_len < RUN_LIMIT) begin
          repeat_len++;
        end else begin
          close_repeat();
          held_px = px;
        end
      end else if (px == held_px) begin
        close_literal();
        repeat_len = 2;
      end else begin
        store_literal(held_px);
        if (literal_len >= RUN_LIMIT) close_literal();
        held_px = px;
      end
      if (last) begin
        if (repeat_len > 0) begin
          close_repeat();
        end else begin
          store_literal(held_px);
          close_literal();
        end
        code_stream.push_back(ROW_TERMINATOR);
        literal_len = 0;
        repeat_len = 0;
        held_px = '0;
        held_ok = 1'b0;
        rows++;
      end
      n_words = (code_stream.size() + PACK_BYTES - 1) / PACK_BYTES;
      for (int unsigned k = 0; k < n_words; k++) begin
        base = k * PACK_BYTES;
        cnt = code_stream.size() - base;
        if (cnt > PACK_BYTES) cnt = PACK_BYTES;
        packed_bytes = '0;
        for (int unsigned j = 0; j < cnt; j++) packed_bytes[63 - 8 * j -: 8] = code_stream[base + j];
        word = {packed_bytes, 4'(cnt), (k + 1 == n_words), (last && k + 1 == n_words)};
        expected_words.push_back(word);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(rle_out_t got);
      rle_out_t want;
      if (expected_words.size() == 0) begin
        $error("result transfer with nothing predicted: %h", got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      compare_field("out_byte_0", want.out_byte_0, got.out_byte_0);
      compare_field("out_byte_1", want.out_byte_1, got.out_byte_1);
      compare_field("out_byte_2", want.out_byte_2, got.out_byte_2);
      compare_field("out_byte_3", want.out_byte_3, got.out_byte_3);
      compare_field("out_byte_4", want.out_byte_4, got.out_byte_4);
      compare_field("out_byte_5", want.out_byte_5, got.out_byte_5);
      compare_field("out_byte_6", want.out_byte_6, got.out_byte_6);
      compare_field("out_byte_7", want.out_byte_7, got.out_byte_7);
      compare_field("byte_count", 8'(want.byte_count), 8'(got.byte_count));
      compare_field("burst_last", 8'(want.burst_last), 8'(got.burst_last));
      compare_field("row_done", 8'(want.row_done), 8'(got.row_done));
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rle_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rle_out_t out_data;

  row_code_scoreboard sb;
  bit          src_eager;
  bit          snk_eager;
  int unsigned cycles;
  logic [7:0]  row_px [$];

  rle_row_encoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned gap_draw(bit eager);
    return eager ? 0 : $urandom_range(0, 8);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_word(out_data);
        stall_left = gap_draw(snk_eager);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  task automatic send_pixel(logic [7:0] px, logic last);
    int unsigned gap;
    gap = gap_draw(src_eager);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{pixel: px, row_end: last};
    do @(posedge clk); while (in_stall);
    sb.note_pixel(px, last);
  endtask

  task automatic send_row();
    src_eager = ($urandom_range(0, 3) == 0);
    snk_eager = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < row_px.size(); i++) send_pixel(row_px[i], i == row_px.size() - 1);
    row_px = {};
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic add_repeat(int unsigned len);
    logic [7:0] v;
    v = $urandom;
    repeat (len) row_px.push_back(v);
  endtask

  task automatic add_literal(int unsigned len);
    logic [7:0] v;
    v = (row_px.size() > 0) ? row_px[$] + 8'($urandom_range(1, 255)) : 8'($urandom);
    repeat (len) begin
      row_px.push_back(v);
      v = v + 8'($urandom_range(1, 255));
    end
  endtask

  task automatic build_random_row();
    int unsigned segs;
    int unsigned len;
    bit          long_seg;
    segs = $urandom_range(1, 5);
    repeat (segs) begin
      long_seg = ($urandom_range(0, 24) == 0);
      len = long_seg ? $urandom_range(120, 135) : $urandom_range(1, 10);
      case ($urandom_range(0, 2))
        0: begin
          add_repeat(len + 1);
        end
        1: begin
          add_literal(len);
        end
        default: begin
          repeat (len) row_px.push_back(8'($urandom_range(0, 3)));
        end
      endcase
    end
  endtask

  initial begin
    int unsigned random_sent;
    sb = new();
    cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    src_eager = 1'b0;
    snk_eager = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row_px = '{8'h00};
    send_row();
    row_px = '{8'hff};
    send_row();
    row_px = '{8'hff, 8'hff};
    send_row();
    row_px = '{8'h00, 8'h01, 8'h80, 8'h7f};
    send_row();
    row_px = '{8'h05, 8'h05, 8'h05, 8'h09};
    send_row();
    row_px = '{8'h01, 8'h02, 8'h03, 8'h03, 8'h03, 8'h04, 8'h04};
    send_row();
    row_px = '{8'h7f, 8'h7f, 8'h7f, 8'h80, 8'h81};
    send_row();
    wait_for_results();

    // A full literal run that closes on the last pixel of its row, then a
    // repeat run that overflows into a second run.
    add_literal(RUN_LIMIT + 1);
    send_row();
    add_repeat(RUN_LIMIT + 2);
    send_row();
    random_sent = 2 * RUN_LIMIT + 3;
    wait_for_results();

    while (random_sent < RANDOM_PIXELS) begin
      build_random_row();
      random_sent += row_px.size();
      send_row();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Encoded %0d pixels in %0d rows; %0d result transfers compared.",
             sb.pixels, sb.rows, sb.words_checked);
    $display("Rows covered single pixels, full literal and repeat runs, and random mixes.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/rle_pkg.sv
hw/rtl/rle_row_encoder_top.sv
tb/rle_row_encoder_top_tb.sv
